/* hw/rtl/ssps_pkg.sv */
`default_nettype none

package ssps_pkg;

  localparam int ADDR_BITS = 24;
  localparam int FRAC_BITS = 16;

  // register and field widths
  localparam int POS_W   = ADDR_BITS + 1;
  localparam int DELTA_W = 32;
  localparam int ACC_W   = DELTA_W + 1;
  localparam int STEPS_W = ACC_W - FRAC_BITS;
  localparam int MAX_W   = (POS_W > STEPS_W) ? POS_W : STEPS_W;
  localparam int P_W     = MAX_W + 2;
  localparam int DVD_W   = MAX_W + 1;
  localparam int CNT_W   = $clog2(DVD_W);
  localparam int SMP_W   = 16;
  localparam int VOL_W   = 9;
  localparam int PROD_W  = SMP_W + VOL_W + 1;
  localparam int VAL_W   = 8;
  localparam int ROW_W   = 12;
  localparam int BASE_W  = 10;
  localparam int CFG_W   = 32;
  localparam int IDX_W   = 3;

  localparam int IN_BITS  = ADDR_BITS + 2 + SMP_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = VAL_W + ROW_W + ADDR_BITS + 2;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  typedef enum logic [IDX_W-1:0] {
    CFG_LOOP_MODE    = 3'd0,
    CFG_WIDE_SAMPLES = 3'd1,
    CFG_VOLUME       = 3'd2,
    CFG_SAMPLE_END   = 3'd3,
    CFG_LOOP_BEGIN   = 3'd4,
    CFG_LOOP_SPAN    = 3'd5,
    CFG_STEP_DELTA   = 3'd6,
    CFG_BASELINE_ROW = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    LOOP_NONE     = 2'd0,
    LOOP_FWD      = 2'd1,
    LOOP_PINGPONG = 2'd2
  } loop_mode_e;

  localparam logic OP_START  = 1'b0;
  localparam logic OP_COLUMN = 1'b1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_STEP  = 6'b000010,
    ST_WRAP  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_APPLY = 6'b010000,
    ST_FIN   = 6'b100000
  } state_e;

endpackage

`default_nettype wire

/* hw/rtl/sample_scope_position_stepper.sv */
// Sequence: a start word goes from idle straight to the finish state; a column word goes
// through the step and wrap states, and the remainder loop and apply state on a loop wrap.
// Throughput: one word at a time; the input is not ready until the previous word
// has reached the output register. The serial remainder loop sets the worst case.
// Reset: configuration, position, fraction, direction and active flag clear to zero.
`default_nettype none

module sample_scope_position_stepper (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // cfg write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ssps_pkg::IDX_W-1:0]  cfg_index_i,
  input  wire logic [ssps_pkg::CFG_W-1:0]  cfg_data_i,
  // input stream
  input  wire logic                        s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata: start_position, start_backwards, start_active, sample_word, zero fill
  input  wire logic [ssps_pkg::IN_W-1:0]   s_axis_tdata_i,
  // tuser: operation
  input  wire logic                        s_axis_tuser_i,
  // output stream
  output logic                             m_axis_tvalid_o,
  input  wire logic                        m_axis_tready_i,
  // tdata: column_value, pixel_row, fetch_address, voice_active,
  //        moving_backwards, zero fill
  output logic [ssps_pkg::OUT_W-1:0]       m_axis_tdata_o
);
  import ssps_pkg::*;

  // configuration
  logic [1:0]           mode_q;
  logic                 wide_q;
  logic [VOL_W-1:0]     vol_q;
  logic [POS_W-1:0]     end_q;
  logic [ADDR_BITS-1:0] beg_q;
  logic [POS_W-1:0]     span_q;
  logic [DELTA_W-1:0]   delta_q;
  logic [BASE_W-1:0]    base_row_q;

  // voice state
  logic [POS_W-1:0]     pos_q, pos_d;
  logic [FRAC_BITS-1:0] frac_q, frac_d;
  logic                 back_q, back_d;
  logic                 act_q, act_d;

  // sequencer and datapath
  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  logic [OUT_W-1:0]     out_q, out_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic signed [P_W-1:0]   p_q, p_d;
  logic signed [P_W-1:0]   wbase_q, wbase_d;
  logic                 sub_q, sub_d;
  logic [POS_W-1:0]     rem_q, rem_d;
  logic [DVD_W-1:0]     dvd_q, dvd_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // input fields
  logic [ADDR_BITS-1:0]    in_pos;
  logic                    in_back;
  logic                    in_act;
  logic signed [SMP_W-1:0] in_smp;

  assign in_pos  = s_axis_tdata_i[ADDR_BITS-1:0];
  assign in_back = s_axis_tdata_i[ADDR_BITS];
  assign in_act  = s_axis_tdata_i[ADDR_BITS+1];
  assign in_smp  = s_axis_tdata_i[ADDR_BITS+2 +: SMP_W];

  logic in_acc;
  logic commit;
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign commit          = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready_i);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

  // scaling product
  logic signed [PROD_W-1:0] prod;
  logic signed [VAL_W-1:0]  scaled;
  assign prod   = in_smp * $signed({1'b0, vol_q});
  assign scaled = wide_q ? prod[23:16] : prod[15:8];

  // step accumulate
  logic [ACC_W-1:0]   acc;
  logic [STEPS_W-1:0] steps;
  assign acc   = ACC_W'(frac_q) + ACC_W'(delta_q);
  assign steps = acc[ACC_W-1:FRAC_BITS];

  // wrap decision terms
  logic signed [P_W-1:0] end_s, beg_s;
  logic                  span_ok, ge_end, lt_beg;
  assign end_s   = $signed(P_W'(end_q));
  assign beg_s   = $signed(P_W'(beg_q));
  assign span_ok = span_q >= POS_W'(2);
  assign ge_end  = p_q >= end_s;
  assign lt_beg  = p_q < beg_s;

  // remainder step
  logic [POS_W:0] trial;
  logic           fits;
  assign trial = {rem_q, dvd_q[DVD_W-1]};
  assign fits  = trial >= {1'b0, span_q};

  // saturation of the stepped position
  logic [POS_W-1:0]     clamped;
  logic [ADDR_BITS-1:0] fetch;
  logic signed [ROW_W-1:0] row;
  always_comb begin
    if (p_q[P_W-1]) begin
      clamped = '0;
    end else if (|p_q[P_W-2:POS_W]) begin
      clamped = '1;
    end else begin
      clamped = p_q[POS_W-1:0];
    end
    fetch = clamped[ADDR_BITS] ? '1 : clamped[ADDR_BITS-1:0];
    row   = $signed(ROW_W'(base_row_q)) - ROW_W'(val_q);
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    frac_d      = frac_q;
    back_d      = back_q;
    act_d       = act_q;
    val_d       = val_q;
    p_d         = p_q;
    wbase_d     = wbase_q;
    sub_d       = sub_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i == OP_START) begin
            p_d     = $signed(P_W'(in_pos));
            frac_d  = '0;
            back_d  = in_back;
            act_d   = in_act;
            val_d   = '0;
            state_d = ST_FIN;
          end else begin
            val_d   = act_q ? scaled : '0;
            state_d = ST_STEP;
          end
        end
      end
      ST_STEP: begin
        frac_d = acc[FRAC_BITS-1:0];
        if (mode_q != LOOP_NONE && mode_q != LOOP_FWD && back_q) begin
          p_d = $signed(P_W'(pos_q)) - $signed(P_W'(steps));
        end else begin
          p_d = $signed(P_W'(pos_q)) + $signed(P_W'(steps));
        end
        state_d = ST_WRAP;
      end
      ST_WRAP: begin
        state_d = ST_FIN;
        rem_d   = '0;
        cnt_d   = CNT_W'(DVD_W - 1);
        case (mode_q)
          LOOP_NONE: begin
            if (ge_end) act_d = 1'b0;
          end
          LOOP_FWD: begin
            if (ge_end) begin
              if (span_ok) begin
                dvd_d   = DVD_W'(p_q - end_s);
                wbase_d = beg_s;
                sub_d   = 1'b0;
                state_d = ST_DIV;
              end else begin
                p_d = beg_s;
              end
            end
          end
          default: begin
            // ping-pong, unused code included
            if (back_q && lt_beg) begin
              back_d = 1'b0;
              if (span_ok) begin
                dvd_d   = DVD_W'(beg_s - p_q - P_W'(1));
                wbase_d = beg_s;
                sub_d   = 1'b0;
                state_d = ST_DIV;
              end else begin
                p_d = beg_s;
              end
            end else if (ge_end) begin
              back_d = 1'b1;
              if (span_ok) begin
                dvd_d   = DVD_W'(p_q - end_s);
                wbase_d = end_s - P_W'(1);
                sub_d   = 1'b1;
                state_d = ST_DIV;
              end else begin
                p_d = end_s - P_W'(1);
              end
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_d = fits ? POS_W'(trial - {1'b0, span_q}) : trial[POS_W-1:0];
        dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) state_d = ST_APPLY;
      end
      ST_APPLY: begin
        p_d     = sub_q ? wbase_q - $signed(P_W'(rem_q)) : wbase_q + $signed(P_W'(rem_q));
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (commit) begin
          pos_d       = clamped;
          out_d       = OUT_W'({back_q, act_q, fetch, row, val_q});
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      frac_q      <= '0;
      back_q      <= 1'b0;
      act_q       <= 1'b0;
      mode_q      <= '0;
      wide_q      <= 1'b0;
      vol_q       <= '0;
      end_q       <= '0;
      beg_q       <= '0;
      span_q      <= '0;
      delta_q     <= '0;
      base_row_q  <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      frac_q      <= frac_d;
      back_q      <= back_d;
      act_q       <= act_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_LOOP_MODE:    mode_q     <= cfg_data_i[1:0];
          CFG_WIDE_SAMPLES: wide_q     <= cfg_data_i[0];
          CFG_VOLUME:       vol_q      <= cfg_data_i[VOL_W-1:0];
          CFG_SAMPLE_END:   end_q      <= cfg_data_i[POS_W-1:0];
          CFG_LOOP_BEGIN:   beg_q      <= cfg_data_i[ADDR_BITS-1:0];
          CFG_LOOP_SPAN:    span_q     <= cfg_data_i[POS_W-1:0];
          CFG_STEP_DELTA:   delta_q    <= cfg_data_i[DELTA_W-1:0];
          CFG_BASELINE_ROW: base_row_q <= cfg_data_i[BASE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    p_q     <= p_d;
    wbase_q <= wbase_d;
    sub_q   <= sub_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    cnt_q   <= cnt_d;
    out_q   <= out_d;
  end

  // remainder stays below the divisor through the whole loop
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < span_q))
    else $error("remainder not below loop span");

  // a word taken in keeps the input closed the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("input ready right after accept");

  // finishing a word always loads the output register
  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> (m_axis_tvalid_o && s_axis_tready_o))
    else $error("finished word not presented");

endmodule

`default_nettype wire

/* tb/tb_sample_scope_position_stepper.sv */
`timescale 1ns / 1ps

module tb_sample_scope_position_stepper;
  import ssps_pkg::*;

  // no name for the spare mode code; the block treats it as ping-pong
  localparam logic [1:0] LOOP_UNUSED = 2'd3;

  localparam int IN_BWD     = ADDR_BITS;
  localparam int IN_ACT     = ADDR_BITS + 1;
  localparam int IN_SMP_LSB = ADDR_BITS + 2;

  localparam int OUT_ROW_LSB  = VAL_W;
  localparam int OUT_ADDR_LSB = VAL_W + ROW_W;
  localparam int OUT_ACT      = OUT_ADDR_LSB + ADDR_BITS;
  localparam int OUT_BWD      = OUT_ACT + 1;

  localparam longint POS_LIMIT  = (longint'(1) << POS_W) - 1;
  localparam longint ADDR_LIMIT = (longint'(1) << ADDR_BITS) - 1;
  localparam logic [CFG_W-1:0] FULL_END = 32'h0100_0000;

  typedef struct {
    logic [VAL_W-1:0]     value;
    logic [ROW_W-1:0]     row;
    logic [ADDR_BITS-1:0] addr;
    logic                 act;
    logic                 bwd;
  } column_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              s_tvalid = 1'b0;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              m_tready = 1'b0;
  wire logic         cfg_ready;
  wire logic         s_tready;
  wire logic         m_tvalid;
  wire logic [OUT_W-1:0] m_tdata;

  sample_scope_position_stepper dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk = ~clk;

  // predictor copy of the registers and voice state
  logic [1:0]           mode_m;
  logic                 wide_m;
  logic [VOL_W-1:0]     vol_m;
  logic [POS_W-1:0]     end_m;
  logic [ADDR_BITS-1:0] beg_m;
  logic [POS_W-1:0]     span_m;
  logic [DELTA_W-1:0]   delta_m;
  logic [BASE_W-1:0]    base_m;
  longint               pos_m;
  logic [FRAC_BITS-1:0] frac_m;
  logic                 bwd_m;
  logic                 act_m;

  column_t expected_cols[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_starts = 0;
  int n_columns = 0;
  int n_writes = 0;
  bit idle_on = 1'b0;
  int stall_left = 0;

  function automatic column_t step_voice(logic op, logic [ADDR_BITS-1:0] spos, logic sbwd,
                                         logic sact, logic [SMP_W-1:0] smp);
    column_t r;
    logic [VAL_W-1:0] val;
    logic [ACC_W-1:0] acc;
    logic [31:0] prod;
    int sample_i;
    int row_i;
    longint steps, p, e, b, sp;
    val = '0;
    if (op == OP_START) begin
      pos_m = longint'(spos);
      frac_m = '0;
      bwd_m = sbwd;
      act_m = sact;
    end else begin
      if (act_m) begin
        sample_i = int'($signed(smp));
        prod = sample_i * int'(vol_m);
        val = wide_m ? prod[23:16] : prod[15:8];
      end
      acc = ACC_W'(frac_m) + ACC_W'(delta_m);
      steps = longint'(acc[ACC_W-1:FRAC_BITS]);
      frac_m = acc[FRAC_BITS-1:0];
      p = pos_m;
      e = longint'(end_m);
      b = longint'(beg_m);
      sp = longint'(span_m);
      case (mode_m)
        LOOP_NONE: begin
          p += steps;
          if (p >= e) act_m = 1'b0;
        end
        LOOP_FWD: begin
          p += steps;
          if (p >= e) p = (sp >= 2) ? b + (p - e) % sp : b;
        end
        default: begin
          p = bwd_m ? p - steps : p + steps;
          if (bwd_m && p < b) begin
            bwd_m = 1'b0;
            p = (sp >= 2) ? b + (b - p - 1) % sp : b;
          end else if (p >= e) begin
            bwd_m = 1'b1;
            p = (sp >= 2) ? (e - 1) - (p - e) % sp : e - 1;
          end
        end
      endcase
      pos_m = (p < 0) ? longint'(0) : (p > POS_LIMIT) ? POS_LIMIT : p;
    end
    row_i = int'(base_m) - int'($signed(val));
    r.value = val;
    r.row = row_i[ROW_W-1:0];
    r.addr = (pos_m > ADDR_LIMIT) ? '1 : pos_m[ADDR_BITS-1:0];
    r.act = act_m;
    r.bwd = bwd_m;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t ns: result %0d: %s got 0x%0h want 0x%0h", $time, n_checked, what, got, want);
    n_errors++;
  endtask

  // output side: random stall bursts
  always @(negedge clk) begin
    if (stall_left != 0) begin
      m_tready = 1'b0;
      stall_left--;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      m_tready = 1'b0;
      stall_left = $urandom_range(0, 11);
    end else begin
      m_tready = 1'b1;
    end
  end

  always @(posedge clk) begin
    column_t got;
    column_t want;
    if (rst_n && m_tvalid && m_tready) begin
      got.value = m_tdata[VAL_W-1:0];
      got.row = m_tdata[OUT_ROW_LSB +: ROW_W];
      got.addr = m_tdata[OUT_ADDR_LSB +: ADDR_BITS];
      got.act = m_tdata[OUT_ACT];
      got.bwd = m_tdata[OUT_BWD];
      if (expected_cols.size() == 0) begin
        report_mismatch("word with nothing pending", longint'(m_tdata), longint'(0));
      end else begin
        want = expected_cols.pop_front();
        n_checked++;
        if (got.value !== want.value)
          report_mismatch("column_value", longint'(got.value), longint'(want.value));
        if (got.row !== want.row)
          report_mismatch("pixel_row", longint'(got.row), longint'(want.row));
        if (got.addr !== want.addr)
          report_mismatch("fetch_address", longint'(got.addr), longint'(want.addr));
        if (got.act !== want.act)
          report_mismatch("voice_active", longint'(got.act), longint'(want.act));
        if (got.bwd !== want.bwd)
          report_mismatch("moving_backwards", longint'(got.bwd), longint'(want.bwd));
      end
    end
  end

  task automatic drain_results();
    while (expected_cols.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
    drain_results();
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LOOP_MODE:    mode_m = val[1:0];
      CFG_WIDE_SAMPLES: wide_m = val[0];
      CFG_VOLUME:       vol_m = val[VOL_W-1:0];
      CFG_SAMPLE_END:   end_m = val[POS_W-1:0];
      CFG_LOOP_BEGIN:   beg_m = val[ADDR_BITS-1:0];
      CFG_LOOP_SPAN:    span_m = val[POS_W-1:0];
      CFG_STEP_DELTA:   delta_m = val;
      CFG_BASELINE_ROW: base_m = val[BASE_W-1:0];
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // entered and left at a falling edge
  task automatic send_word(logic op, logic [ADDR_BITS-1:0] spos, logic sbwd, logic sact,
                           logic [SMP_W-1:0] smp);
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 12)) @(negedge clk);
    s_tuser = op;
    s_tdata = '0;
    s_tdata[ADDR_BITS-1:0] = spos;
    s_tdata[IN_BWD] = sbwd;
    s_tdata[IN_ACT] = sact;
    s_tdata[IN_SMP_LSB +: SMP_W] = smp;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    expected_cols.push_back(step_voice(op, spos, sbwd, sact, smp));
    if (op == OP_START) n_starts++;
    else n_columns++;
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic send_start(logic [ADDR_BITS-1:0] spos, logic sbwd, logic sact);
    send_word(OP_START, spos, sbwd, sact, SMP_W'($urandom));
  endtask

  task automatic send_column(logic [SMP_W-1:0] smp);
    send_word(OP_COLUMN, ADDR_BITS'($urandom), 1'($urandom), 1'($urandom), smp);
  endtask

  function automatic logic [SMP_W-1:0] random_sample();
    logic [7:0] narrow;
    narrow = 8'($urandom);
    if (!wide_m && $urandom_range(0, 3) != 0) return {{8{narrow[7]}}, narrow};
    return SMP_W'($urandom);
  endfunction

  task automatic test_reset_state();
    send_column(16'h7FFF);
    send_start('1, 1'b1, 1'b1);
    send_column(16'h8000);
  endtask

  task automatic test_sample_scaling();
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_NONE));
    write_reg(CFG_SAMPLE_END, FULL_END);
    write_reg(CFG_STEP_DELTA, 0);
    write_reg(CFG_VOLUME, 256);
    write_reg(CFG_BASELINE_ROW, 1023);
    send_start(24'h123456, 1'b0, 1'b1);
    send_column(16'h7FFF);
    send_column(16'h8000);
    send_column(16'h007F);
    send_column(16'hFF80);
    // volume past 256 wraps the kept byte
    write_reg(CFG_VOLUME, 511);
    write_reg(CFG_BASELINE_ROW, 0);
    send_column(16'h7FFF);
    write_reg(CFG_WIDE_SAMPLES, 1);
    write_reg(CFG_VOLUME, 256);
    send_column(16'h8000);
    send_column(16'h7FFF);
    // inactive voice shows the zero line
    send_start(24'h000000, 1'b0, 1'b0);
    send_column(16'h7FFF);
  endtask

  task automatic test_loop_modes();
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_FWD));
    write_reg(CFG_SAMPLE_END, 100);
    write_reg(CFG_LOOP_BEGIN, 20);
    write_reg(CFG_LOOP_SPAN, 80);
    write_reg(CFG_STEP_DELTA, 32'h0003_8000);
    write_reg(CFG_BASELINE_ROW, 500);
    send_start(24'd95, 1'b0, 1'b1);
    send_column(16'h1234);
    send_column(16'hEDCB);
    // loop shorter than two samples snaps to the loop start
    write_reg(CFG_LOOP_SPAN, 1);
    send_column(16'h0101);
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_NONE));
    send_start(24'd98, 1'b0, 1'b1);
    send_column(16'h4000);
    send_column(16'h4000);
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_PINGPONG));
    write_reg(CFG_LOOP_SPAN, 80);
    send_start(24'd95, 1'b0, 1'b1);
    send_column(16'h2222);
    send_start(24'd21, 1'b1, 1'b1);
    send_column(16'hC000);
    write_reg(CFG_LOOP_SPAN, 0);
    send_start(24'd99, 1'b0, 1'b1);
    send_column(16'h0F0F);
    send_start(24'd20, 1'b1, 1'b1);
    send_column(16'hF0F0);
    // turn back below zero saturates the position
    write_reg(CFG_SAMPLE_END, 4);
    write_reg(CFG_LOOP_BEGIN, 0);
    write_reg(CFG_LOOP_SPAN, 100);
    write_reg(CFG_STEP_DELTA, 32'h000A_0000);
    send_start(24'd3, 1'b0, 1'b1);
    send_column(16'h7F00);
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_UNUSED));
    send_column(16'h8080);
  endtask

  // no loop with the largest step runs the position into its ceiling
  task automatic test_position_saturation();
    idle_on = 1'b1;
    write_reg(CFG_LOOP_MODE, CFG_W'(LOOP_NONE));
    write_reg(CFG_SAMPLE_END, FULL_END);
    write_reg(CFG_STEP_DELTA, 32'hFFFF_FFFF);
    send_start(24'hFFFFF0, 1'b0, 1'b1);
    repeat (270) send_column(random_sample());
  endtask

  task automatic apply_random_setting();
    int sel;
    logic [CFG_W-1:0] e, b, sp, val;
    sel = $urandom_range(0, 9);
    write_reg(CFG_LOOP_MODE, CFG_W'((sel < 3) ? LOOP_NONE : (sel < 6) ? LOOP_FWD :
              (sel < 9) ? LOOP_PINGPONG : LOOP_UNUSED));
    write_reg(CFG_WIDE_SAMPLES, $urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0: val = 0;
      1: val = 256;
      2: val = $urandom_range(257, 511);
      default: val = $urandom_range(1, 256);
    endcase
    write_reg(CFG_VOLUME, val);
    case ($urandom_range(0, 7))
      0: begin
        e = 0;
        b = $urandom_range(0, 32'hFF_FFFF);
        sp = $urandom_range(0, 3);
      end
      1: begin
        e = FULL_END;
        b = $urandom_range(0, 32'hFF_FFFF);
        sp = $urandom_range(0, FULL_END);
      end
      default: begin
        e = $urandom_range(1, 4096);
        b = $urandom_range(0, e - 1);
        case ($urandom_range(0, 3))
          0: sp = $urandom_range(0, 1);
          1: sp = $urandom_range(0, FULL_END);
          default: sp = e - b;
        endcase
      end
    endcase
    write_reg(CFG_SAMPLE_END, e);
    write_reg(CFG_LOOP_BEGIN, b);
    write_reg(CFG_LOOP_SPAN, sp);
    case ($urandom_range(0, 7))
      0: val = 0;
      1: val = 32'hFFFF_FFFF;
      2: val = $urandom;
      default: val = $urandom_range(1, 32'h0004_0000);
    endcase
    write_reg(CFG_STEP_DELTA, val);
    case ($urandom_range(0, 3))
      0: val = 0;
      1: val = 1023;
      default: val = $urandom_range(0, 1023);
    endcase
    write_reg(CFG_BASELINE_ROW, val);
  endtask

  task automatic test_random_runs(int n_items);
    int sent;
    logic [ADDR_BITS-1:0] spos;
    sent = 0;
    while (sent < n_items) begin
      idle_on = (sent < n_items - 150) && ($urandom_range(0, 3) != 0);
      apply_random_setting();
      if (end_m != 0 && $urandom_range(0, 3) != 0)
        spos = ADDR_BITS'($urandom_range(0, end_m - 1));
      else spos = ADDR_BITS'($urandom);
      send_start(spos, 1'($urandom_range(0, 1)), $urandom_range(0, 7) != 0);
      sent++;
      repeat ($urandom_range(8, 80)) begin
        if ($urandom_range(0, 24) == 0)
          send_start(ADDR_BITS'($urandom), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        else
          send_column(random_sample());
        if ($urandom_range(0, 60) == 0) drain_results();
        sent++;
      end
    end
  endtask

  initial begin
    mode_m = '0;
    wide_m = 1'b0;
    vol_m = '0;
    end_m = '0;
    beg_m = '0;
    span_m = '0;
    delta_m = '0;
    base_m = '0;
    pos_m = 0;
    frac_m = '0;
    bwd_m = 1'b0;
    act_m = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_state();
    test_sample_scaling();
    test_loop_modes();
    test_position_saturation();
    test_random_runs(900);

    idle_on = 1'b0;
    drain_results();
    // leave room for a stray word to show up
    repeat (64) @(negedge clk);
    $display("Ran %0d start and %0d column words across %0d register writes,",
             n_starts, n_columns, n_writes);
    $display("all loop modes and both sample widths; %0d results checked, %0d mismatches.",
             n_checked, n_errors);
    if (n_errors == 0 && expected_cols.size() == 0) begin
      $display("sample_scope_position_stepper test passed");
    end else begin
      $display("sample_scope_position_stepper test failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results pending.", expected_cols.size());
    $display("sample_scope_position_stepper test failed");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/ssps_pkg.sv
hw/rtl/sample_scope_position_stepper.sv
tb/tb_sample_scope_position_stepper.sv
